FILE: rtl/core/rcda_pkg.sv
`default_nettype none

package rcda_pkg;

  // Channel and register widths.
  localparam int unsigned RAW_W   = 12;
  localparam int unsigned DBL_W   = 13;
  localparam int unsigned CMD_W   = 14;
  localparam int unsigned DB_W    = 10;
  localparam int unsigned SLOPE_W = 16;
  localparam int unsigned Q_SHIFT = 14;
  localparam int unsigned NUM_CH  = 6;
  localparam int unsigned NUM_AXES = 3;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned OUT_TDATA_W = 72;

  // Channel slots in the held frame.
  localparam int unsigned CH_ROLL  = 0;
  localparam int unsigned CH_PITCH = 1;
  localparam int unsigned CH_YAW   = 2;
  localparam int unsigned CH_THR   = 3;
  localparam int unsigned CH_AUX1  = 4;
  localparam int unsigned CH_AUX3  = 5;

  // Saturation magnitudes of the stick commands.
  localparam logic [CMD_W-1:0] CMD_POS_LIM = 14'd8191;
  localparam logic [CMD_W-1:0] CMD_NEG_LIM = 14'd8192;

  // Reset values.
  localparam logic [RAW_W-1:0]   STICK_RST     = 12'd1500;
  localparam logic [RAW_W-1:0]   AUX_RST       = 12'd0;
  localparam logic [DBL_W-1:0]   MID_RST       = 13'd3000;
  localparam logic [DB_W-1:0]    DEADBAND_RST  = 10'd40;
  localparam logic [SLOPE_W-1:0] SLOPE_RST     = 16'd16384;
  localparam logic [DBL_W-1:0]   MIN_CHECK_RST = 13'd2200;
  localparam logic [DBL_W-1:0]   MAX_CHECK_RST = 13'd3800;
  localparam logic [DBL_W-1:0]   MIN_THR_RST   = 13'd2300;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MID_COMMAND    = 3'd0,
    CFG_DEADBAND       = 3'd1,
    CFG_DEADBAND_SLOPE = 3'd2,
    CFG_MIN_CHECK      = 3'd3,
    CFG_MAX_CHECK      = 3'd4,
    CFG_MIN_THROTTLE   = 3'd5
  } cfg_index_e;

  typedef struct packed {
    logic is_armed;
    logic pid_reset;
    logic zero_pid_pulse;
    logic gyro_cal_request;
    logic pid_init_request;
    logic rt_data_request;
  } arm_flags_t;

endpackage

`default_nettype wire

FILE: rtl/core/rc_command_deadband_arming.sv
`default_nettype none

// RC command conditioner. Each input item is one receiver frame: tdata
// carries roll, pitch, yaw, throttle, aux1 and aux3 (12 bits each) and
// tuser is rc_active; a frame with rc_active low reuses the last fresh
// channels. The block takes one item per clock cycle while the output is
// not stalled and offers its result from the result register: the frame
// is latched in the held channel register, and the deadband multipliers
// and arming logic feed the result register. s_axis_tready follows
// m_axis_tready combinationally, so the block stalls only while both stages
// hold an item and the result is not being taken. Configuration registers
// may be written only while no item is in flight.
module rc_command_deadband_arming (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // roll_raw, pitch_raw, yaw_raw, throttle_raw, aux1_raw, aux3_raw
  input  logic [rcda_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // rc_active
  input  logic                                 s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // roll_cmd, pitch_cmd, yaw_cmd, throttle_cmd, detent_flags, is_armed,
  // rate_mode, pid_reset, zero_pid_pulse, gyro_cal_request,
  // pid_init_request, rt_data_request, zero fill
  output logic [rcda_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [rcda_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [rcda_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import rcda_pkg::*;

  localparam int unsigned PAYLOAD_W = NUM_AXES * CMD_W + DBL_W + NUM_AXES + 7;

  logic [DBL_W-1:0]   mid_q, min_check_q, max_check_q, min_thr_q;
  logic [DB_W-1:0]    db_q;
  logic [SLOPE_W-1:0] slope_q;

  logic [RAW_W-1:0]   held_q [NUM_CH];
  logic               s1_valid_q;
  logic               out_valid_q;
  logic [PAYLOAD_W-1:0] out_data_q, out_data_d;

  logic               in_accept, advance, out_free;
  logic signed [CMD_W-1:0] cmd [NUM_AXES];
  logic [NUM_AXES-1:0] detent;
  logic [DBL_W-1:0]   thr, aux1, aux3;
  logic               rate_mode;
  arm_flags_t         flags;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q       <= MID_RST;
      db_q        <= DEADBAND_RST;
      slope_q     <= SLOPE_RST;
      min_check_q <= MIN_CHECK_RST;
      max_check_q <= MAX_CHECK_RST;
      min_thr_q   <= MIN_THR_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MID_COMMAND:    mid_q       <= cfg_data_i[DBL_W-1:0];
        CFG_DEADBAND:       db_q        <= cfg_data_i[DB_W-1:0];
        CFG_DEADBAND_SLOPE: slope_q     <= cfg_data_i[SLOPE_W-1:0];
        CFG_MIN_CHECK:      min_check_q <= cfg_data_i[DBL_W-1:0];
        CFG_MAX_CHECK:      max_check_q <= cfg_data_i[DBL_W-1:0];
        CFG_MIN_THROTTLE:   min_thr_q   <= cfg_data_i[DBL_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = s1_valid_q && out_free;
  assign s_axis_tready = !s1_valid_q || out_free;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // The held channels double as the input register of the pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q[CH_ROLL]  <= STICK_RST;
      held_q[CH_PITCH] <= STICK_RST;
      held_q[CH_YAW]   <= STICK_RST;
      held_q[CH_THR]   <= STICK_RST;
      held_q[CH_AUX1]  <= AUX_RST;
      held_q[CH_AUX3]  <= AUX_RST;
      s1_valid_q       <= 1'b0;
    end else begin
      if (in_accept && s_axis_tuser) begin
        for (int i = 0; i < NUM_CH; i++) begin
          held_q[i] <= s_axis_tdata[i*RAW_W +: RAW_W];
        end
      end
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    rcda_axis u_axis (
      .raw_i    (held_q[a]),
      .mid_i    (mid_q),
      .db_i     (db_q),
      .slope_i  (slope_q),
      .cmd_o    (cmd[a]),
      .inside_o (detent[a])
    );
  end

  assign thr       = {held_q[CH_THR], 1'b0};
  assign aux1      = {held_q[CH_AUX1], 1'b0};
  assign aux3      = {held_q[CH_AUX3], 1'b0};
  assign rate_mode = (aux3 > mid_q);

  rcda_arm u_arm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .roll_i      (cmd[CH_ROLL]),
    .pitch_i     (cmd[CH_PITCH]),
    .yaw_i       (cmd[CH_YAW]),
    .thr_i       (thr),
    .aux1_i      (aux1),
    .mid_i       (mid_q),
    .min_check_i (min_check_q),
    .max_check_i (max_check_q),
    .min_thr_i   (min_thr_q),
    .flags_o     (flags)
  );

  assign out_data_d = {flags.rt_data_request, flags.pid_init_request,
                       flags.gyro_cal_request, flags.zero_pid_pulse,
                       flags.pid_reset, rate_mode, flags.is_armed, detent, thr,
                       cmd[CH_YAW], cmd[CH_PITCH], cmd[CH_ROLL]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W - PAYLOAD_W){1'b0}}, out_data_q};

`ifndef SYNTHESIS
  a_detent_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[3*CMD_W + DBL_W] |-> m_axis_tdata[CMD_W-1:0] == '0)
    else $error("roll inside deadband but command not zero");

  a_disarmed_pid_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !out_data_q[PAYLOAD_W-7] |-> out_data_q[PAYLOAD_W-5])
    else $error("pid_reset low while disarmed");

  a_gesture_disarmed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (out_data_q[PAYLOAD_W-1] || out_data_q[PAYLOAD_W-2] ||
                      out_data_q[PAYLOAD_W-3])
    |-> !out_data_q[PAYLOAD_W-7] && out_data_q[PAYLOAD_W-4])
    else $error("gesture request on an armed frame");

  a_stale_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && !s_axis_tuser |=> held_q[CH_ROLL] == $past(held_q[CH_ROLL]) &&
                                   held_q[CH_AUX1] == $past(held_q[CH_AUX1]))
    else $error("stale frame changed the held channels");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/rcda_axis.sv
`default_nettype none

module rcda_axis (
  input  logic [rcda_pkg::RAW_W-1:0]   raw_i,
  input  logic [rcda_pkg::DBL_W-1:0]   mid_i,
  input  logic [rcda_pkg::DB_W-1:0]    db_i,
  input  logic [rcda_pkg::SLOPE_W-1:0] slope_i,
  output logic signed [rcda_pkg::CMD_W-1:0] cmd_o,
  output logic                         inside_o
);
  import rcda_pkg::*;

  localparam int unsigned CW = CMD_W + 1;
  localparam int unsigned PW = CMD_W + SLOPE_W;

  logic signed [CW-1:0]      centred;
  logic [CW-1:0]             neg_centred;
  logic                      neg;
  logic [CMD_W-1:0]          abs_c;
  logic [CMD_W-1:0]          mag;
  logic [PW-1:0]             prod;
  logic [PW-Q_SHIFT-1:0]     scaled;
  logic [CMD_W-1:0]          lim;

  always_comb begin
    centred     = $signed({2'b00, raw_i, 1'b0}) - $signed({2'b00, mid_i});
    neg         = centred[CW-1];
    neg_centred = -centred;
    abs_c       = neg ? neg_centred[CMD_W-1:0] : centred[CMD_W-1:0];
    inside_o    = (abs_c <= CMD_W'(db_i));
    mag         = abs_c - CMD_W'(db_i);
    prod        = PW'(mag) * PW'(slope_i);
    scaled      = prod[PW-1:Q_SHIFT];
    // The negative side reaches one step further than the positive side.
    if (neg) begin
      lim = (scaled > (PW-Q_SHIFT)'(CMD_NEG_LIM)) ? CMD_NEG_LIM : scaled[CMD_W-1:0];
    end else begin
      lim = (scaled > (PW-Q_SHIFT)'(CMD_POS_LIM)) ? CMD_POS_LIM : scaled[CMD_W-1:0];
    end
    if (inside_o) begin
      cmd_o = '0;
    end else if (neg) begin
      cmd_o = $signed(-lim);
    end else begin
      cmd_o = $signed(lim);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/rcda_arm.sv
`default_nettype none

module rcda_arm (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              advance_i,
  input  logic signed [rcda_pkg::CMD_W-1:0] roll_i,
  input  logic signed [rcda_pkg::CMD_W-1:0] pitch_i,
  input  logic signed [rcda_pkg::CMD_W-1:0] yaw_i,
  input  logic [rcda_pkg::DBL_W-1:0]        thr_i,
  input  logic [rcda_pkg::DBL_W-1:0]        aux1_i,
  input  logic [rcda_pkg::DBL_W-1:0]        mid_i,
  input  logic [rcda_pkg::DBL_W-1:0]        min_check_i,
  input  logic [rcda_pkg::DBL_W-1:0]        max_check_i,
  input  logic [rcda_pkg::DBL_W-1:0]        min_thr_i,
  output rcda_pkg::arm_flags_t              flags_o
);
  import rcda_pkg::*;

  logic                    armed_q, armed_d;
  logic                    disarm, arm_go;
  logic signed [CMD_W-1:0] lo, hi;

  always_comb begin
    lo     = $signed({1'b0, min_check_i}) - $signed({1'b0, mid_i});
    hi     = $signed({1'b0, max_check_i}) - $signed({1'b0, mid_i});
    disarm = (aux1_i < mid_i);
    arm_go = (aux1_i > mid_i) && (thr_i < min_check_i) && !armed_q;
    if (disarm) begin
      armed_d = 1'b0;
    end else if (arm_go) begin
      armed_d = 1'b1;
    end else begin
      armed_d = armed_q;
    end
    flags_o.is_armed         = armed_d;
    flags_o.pid_reset        = !(armed_d && (thr_i > min_thr_i));
    flags_o.zero_pid_pulse   = disarm || arm_go;
    // Stick gestures count only on a frame with the arm switch off.
    flags_o.gyro_cal_request = disarm && (yaw_i < lo) && (roll_i > hi) && (pitch_i < lo);
    flags_o.pid_init_request = disarm && (yaw_i < lo) && (roll_i > hi) && (pitch_i > hi);
    flags_o.rt_data_request  = disarm && (yaw_i > lo) && (roll_i < hi) && (pitch_i < lo);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= 1'b0;
    end else if (advance_i) begin
      armed_q <= armed_d;
    end
  end

endmodule

`default_nettype wire

FILE: sim/rc_command_deadband_arming_tb.sv
`timescale 1ns / 1ps

module rc_command_deadband_arming_tb;
  import rcda_pkg::*;

  localparam int STALL_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 4;
  localparam int RAW_MAX       = 4095;
  localparam int DBL_MAX       = 8190;
  localparam int MAG_CAP       = 9000;
  localparam int CMD_HI        = 8191;
  localparam int CMD_LO        = -8192;
  localparam int SEGMENT_ITEMS = 146;
  localparam int REPORT_LINES  = 100;

  // Bit positions of the result fields in m_axis_tdata.
  localparam int THR_LSB  = 3 * CMD_W;
  localparam int DET_LSB  = THR_LSB + DBL_W;
  localparam int FLAG_LSB = DET_LSB + NUM_AXES;

  // Index outside the register map; a write to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

  typedef struct {
    int roll;
    int pitch;
    int yaw;
    int throttle;
    int detent;
    int armed;
    int rate;
    int pid_reset;
    int zero_pulse;
    int gyro_cal;
    int pid_init;
    int rt_data;
  } stick_cmds_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata  = '0;
  logic                  s_axis_tuser  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  // Predicted register contents and block state.
  logic [DBL_W-1:0]   mid_cmd_q;
  logic [DB_W-1:0]    deadband_q;
  logic [SLOPE_W-1:0] slope_q;
  logic [DBL_W-1:0]   min_check_q;
  logic [DBL_W-1:0]   max_check_q;
  logic [DBL_W-1:0]   min_thr_q;
  logic               armed_q;
  logic [RAW_W-1:0]   held_q [NUM_CH];

  stick_cmds_t pending_cmds [$];
  int          mismatches    = 0;
  int          src_idle_pct  = 0;
  int          sink_idle_pct = 0;
  int          quiet_cycles  = 0;

  always #5 clk_i = ~clk_i;

  rc_command_deadband_arming dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  task automatic reset_model();
    mid_cmd_q   = MID_RST;
    deadband_q  = DEADBAND_RST;
    slope_q     = SLOPE_RST;
    min_check_q = MIN_CHECK_RST;
    max_check_q = MAX_CHECK_RST;
    min_thr_q   = MIN_THR_RST;
    armed_q     = 1'b0;
    for (int i = 0; i < NUM_CH; i++) begin
      held_q[i] = (i < CH_AUX1) ? STICK_RST : AUX_RST;
    end
  endtask

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_MID_COMMAND:    mid_cmd_q   = val[DBL_W-1:0];
      CFG_DEADBAND:       deadband_q  = val[DB_W-1:0];
      CFG_DEADBAND_SLOPE: slope_q     = val[SLOPE_W-1:0];
      CFG_MIN_CHECK:      min_check_q = val[DBL_W-1:0];
      CFG_MAX_CHECK:      max_check_q = val[DBL_W-1:0];
      CFG_MIN_THROTTLE:   min_thr_q   = val[DBL_W-1:0];
      default: ;
    endcase
  endfunction

  // Centres a doubled stick, applies the deadband and the Q2.14 slope, and
  // rounds toward zero before saturating.
  function automatic int shape_stick(input logic [RAW_W-1:0] raw, output logic hit);
    int    c;
    int    db;
    longint mag;
    c   = 2 * int'(raw) - int'(mid_cmd_q);
    db  = int'(deadband_q);
    hit = (c <= db) && (c >= -db);
    if (hit) return 0;
    mag = (c > 0) ? c - db : -c - db;
    mag = (mag * longint'(slope_q)) >>> Q_SHIFT;
    if (mag > MAG_CAP) mag = MAG_CAP;
    if (c > 0) return (mag > CMD_HI) ? CMD_HI : int'(mag);
    return (-mag < CMD_LO) ? CMD_LO : -int'(mag);
  endfunction

  function automatic stick_cmds_t condition_frame(input logic active,
                                                  input logic [IN_TDATA_W-1:0] data);
    stick_cmds_t           r;
    int                    cmd [NUM_AXES];
    logic [NUM_AXES-1:0]   det_bits;
    logic                  hit;
    int                    thr;
    int                    aux1;
    int                    aux3;
    int                    mid;
    int                    lo;
    int                    hi;
    if (active) begin
      for (int i = 0; i < NUM_CH; i++) held_q[i] = data[i*RAW_W +: RAW_W];
    end
    for (int a = 0; a < NUM_AXES; a++) begin
      cmd[a]      = shape_stick(held_q[a], hit);
      det_bits[a] = hit;
    end
    thr  = 2 * int'(held_q[CH_THR]);
    aux1 = 2 * int'(held_q[CH_AUX1]);
    aux3 = 2 * int'(held_q[CH_AUX3]);
    mid  = int'(mid_cmd_q);
    lo   = int'(min_check_q) - mid;
    hi   = int'(max_check_q) - mid;
    r.zero_pulse = 0;
    r.gyro_cal   = 0;
    r.pid_init   = 0;
    r.rt_data    = 0;
    // Gestures are only read on a disarm frame.
    if (aux1 < mid) begin
      armed_q      = 1'b0;
      r.zero_pulse = 1;
      r.gyro_cal   = (cmd[CH_YAW] < lo && cmd[CH_ROLL] > hi && cmd[CH_PITCH] < lo);
      r.pid_init   = (cmd[CH_YAW] < lo && cmd[CH_ROLL] > hi && cmd[CH_PITCH] > hi);
      r.rt_data    = (cmd[CH_YAW] > lo && cmd[CH_ROLL] < hi && cmd[CH_PITCH] < lo);
    end
    if (aux1 > mid && thr < int'(min_check_q) && !armed_q) begin
      armed_q      = 1'b1;
      r.zero_pulse = 1;
    end
    r.roll      = cmd[CH_ROLL];
    r.pitch     = cmd[CH_PITCH];
    r.yaw       = cmd[CH_YAW];
    r.throttle  = thr;
    r.detent    = det_bits;
    r.armed     = armed_q;
    r.rate      = (aux3 > mid);
    r.pid_reset = !(armed_q && thr > int'(min_thr_q));
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < REPORT_LINES) $display("mismatch at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic compare_field(input string name, input int got, input int want);
    if (got != want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  always @(posedge clk_i) begin : result_check
    stick_cmds_t got;
    stick_cmds_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.roll       = $signed(m_axis_tdata[0 +: CMD_W]);
      got.pitch      = $signed(m_axis_tdata[CMD_W +: CMD_W]);
      got.yaw        = $signed(m_axis_tdata[2*CMD_W +: CMD_W]);
      got.throttle   = m_axis_tdata[THR_LSB +: DBL_W];
      got.detent     = m_axis_tdata[DET_LSB +: NUM_AXES];
      got.armed      = m_axis_tdata[FLAG_LSB];
      got.rate       = m_axis_tdata[FLAG_LSB + 1];
      got.pid_reset  = m_axis_tdata[FLAG_LSB + 2];
      got.zero_pulse = m_axis_tdata[FLAG_LSB + 3];
      got.gyro_cal   = m_axis_tdata[FLAG_LSB + 4];
      got.pid_init   = m_axis_tdata[FLAG_LSB + 5];
      got.rt_data    = m_axis_tdata[FLAG_LSB + 6];
      if (pending_cmds.size() == 0) begin
        report_mismatch("result item with no frame outstanding");
      end else begin
        want = pending_cmds.pop_front();
        compare_field("roll_cmd", got.roll, want.roll);
        compare_field("pitch_cmd", got.pitch, want.pitch);
        compare_field("yaw_cmd", got.yaw, want.yaw);
        compare_field("throttle_cmd", got.throttle, want.throttle);
        compare_field("detent_flags", got.detent, want.detent);
        compare_field("is_armed", got.armed, want.armed);
        compare_field("rate_mode", got.rate, want.rate);
        compare_field("pid_reset", got.pid_reset, want.pid_reset);
        compare_field("zero_pid_pulse", got.zero_pulse, want.zero_pulse);
        compare_field("gyro_cal_request", got.gyro_cal, want.gyro_cal);
        compare_field("pid_init_request", got.pid_init, want.pid_init);
        compare_field("rt_data_request", got.rt_data, want.rt_data);
      end
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= (int'($urandom_range(99)) >= sink_idle_pct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [IN_TDATA_W-1:0] pack_frame(
    input logic [RAW_W-1:0] roll, input logic [RAW_W-1:0] pitch,
    input logic [RAW_W-1:0] yaw, input logic [RAW_W-1:0] thr,
    input logic [RAW_W-1:0] aux1, input logic [RAW_W-1:0] aux3);
    return {aux3, aux1, thr, yaw, pitch, roll};
  endfunction

  // Raw value whose doubled value lies at or nearest below the target.
  function automatic logic [RAW_W-1:0] raw_at(input int doubled);
    if (doubled <= 0) return '0;
    if (doubled >= 2 * RAW_MAX) return RAW_W'(RAW_MAX);
    return RAW_W'(doubled / 2);
  endfunction

  function automatic int jitter(input int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  function automatic int clip_dbl(input int val);
    if (val < 0) return 0;
    if (val > DBL_MAX) return DBL_MAX;
    return val;
  endfunction

  // Now and then sets bits above the register width, which must be dropped.
  function automatic logic [CFG_DATA_W-1:0] noisy_reg(input int val, input int width);
    logic [CFG_DATA_W-1:0] v;
    v = val[CFG_DATA_W-1:0];
    if ($urandom_range(7) == 0) v = v | (CFG_DATA_W'($urandom_range(16'hFFFF)) << width);
    return v;
  endfunction

  function automatic logic [RAW_W-1:0] pick_stick();
    int mid;
    int db;
    int dir;
    mid = int'(mid_cmd_q);
    db  = int'(deadband_q);
    dir = $urandom_range(1) ? 1 : -1;
    case ($urandom_range(4))
      0: return raw_at(mid + dir * (db + jitter(3)));
      1: return raw_at(mid + jitter(db));
      2: return raw_at(($urandom_range(1) ? int'(min_check_q) : int'(max_check_q)) +
                       dir * db + jitter(4));
      3: return $urandom_range(1) ? RAW_W'($urandom_range(2))
                                  : RAW_W'(RAW_MAX - int'($urandom_range(2)));
      default: return RAW_W'($urandom_range(RAW_MAX));
    endcase
  endfunction

  function automatic logic [RAW_W-1:0] pick_switch();
    case ($urandom_range(3))
      0: return raw_at(int'(mid_cmd_q) + jitter(2));
      1: return RAW_W'($urandom_range(40));
      2: return RAW_W'(RAW_MAX - int'($urandom_range(40)));
      default: return RAW_W'($urandom_range(RAW_MAX));
    endcase
  endfunction

  task automatic send_frame(input logic active, input logic [IN_TDATA_W-1:0] data);
    while (int'($urandom_range(99)) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= active;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_cmds.push_back(condition_frame(active, data));
  endtask

  // Holds the sender back until every outstanding result item has come.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_cmds.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    apply_reg(idx, val);
  endtask

  task automatic program_regs(input logic [CFG_DATA_W-1:0] mid, input logic [CFG_DATA_W-1:0] db,
                              input logic [CFG_DATA_W-1:0] slope,
                              input logic [CFG_DATA_W-1:0] min_check,
                              input logic [CFG_DATA_W-1:0] max_check,
                              input logic [CFG_DATA_W-1:0] min_thr);
    wait_idle();
    write_reg(CFG_MID_COMMAND, mid);
    write_reg(CFG_DEADBAND, db);
    write_reg(CFG_DEADBAND_SLOPE, slope);
    write_reg(CFG_MIN_CHECK, min_check);
    write_reg(CFG_MAX_CHECK, max_check);
    write_reg(CFG_MIN_THROTTLE, min_thr);
    write_reg(CFG_UNUSED_IDX, CFG_DATA_W'($urandom_range(16'hFFFF)));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic program_random_regs();
    int mid;
    int db;
    int slope;
    int min_check;
    int max_check;
    int min_thr;
    mid = ($urandom_range(3) == 0) ? int'($urandom_range(DBL_MAX))
                                   : 2000 + int'($urandom_range(2000));
    db  = ($urandom_range(3) == 0) ? int'($urandom_range(1000)) : int'($urandom_range(120));
    case ($urandom_range(2))
      0: slope = SLOPE_RST;
      1: slope = 8192 + int'($urandom_range(24576));
      default: slope = $urandom_range(16'hFFFF);
    endcase
    min_check = clip_dbl(mid - 200 - int'($urandom_range(1500)));
    max_check = clip_dbl(mid + 200 + int'($urandom_range(1500)));
    min_thr   = $urandom_range(1) ? clip_dbl(min_check + jitter(500))
                                  : int'($urandom_range(DBL_MAX));
    program_regs(noisy_reg(mid, DBL_W), noisy_reg(db, DB_W), noisy_reg(slope, SLOPE_W),
                 noisy_reg(min_check, DBL_W), noisy_reg(max_check, DBL_W),
                 noisy_reg(min_thr, DBL_W));
  endtask

  // Mostly well-formed arm, disarm-gesture and flight frames, with stale and
  // unstructured frames mixed in.
  task automatic send_random_frame();
    logic [RAW_W-1:0] roll;
    logic [RAW_W-1:0] pitch;
    logic [RAW_W-1:0] yaw;
    logic [RAW_W-1:0] thr;
    logic [RAW_W-1:0] aux1;
    logic [RAW_W-1:0] aux3;
    logic [RAW_W-1:0] low_s;
    logic [RAW_W-1:0] high_s;
    int               mid;
    int               kind;
    mid    = int'(mid_cmd_q);
    low_s  = RAW_W'($urandom_range(200));
    high_s = RAW_W'(RAW_MAX - int'($urandom_range(200)));
    roll   = pick_stick();
    pitch  = pick_stick();
    yaw    = pick_stick();
    thr    = RAW_W'($urandom_range(RAW_MAX));
    aux1   = pick_switch();
    aux3   = pick_switch();
    kind   = $urandom_range(99);
    if (kind < 15) begin
      aux1 = raw_at(mid + 1 + int'($urandom_range(600)));
      thr  = raw_at(int'(min_check_q) - int'($urandom_range(60)));
    end else if (kind < 35) begin
      aux1 = raw_at(mid - 1 - int'($urandom_range(600)));
      case ($urandom_range(3))
        0: begin
          yaw = low_s;
          roll = high_s;
          pitch = low_s;
        end
        1: begin
          yaw = low_s;
          roll = high_s;
          pitch = high_s;
        end
        2: begin
          yaw = high_s;
          roll = low_s;
          pitch = low_s;
        end
        default: ;
      endcase
    end else if (kind < 70) begin
      aux1 = raw_at(mid + 1 + int'($urandom_range(2000)));
      if ($urandom_range(1)) thr = raw_at(int'(min_thr_q) + jitter(8));
    end
    send_frame((kind >= 90) ? 1'b0 : 1'b1, pack_frame(roll, pitch, yaw, thr, aux1, aux3));
  endtask

  task automatic test_reset_extremes();
    send_frame(1'b1, pack_frame(0, 0, 0, 0, 0, 0));
    send_frame(1'b1, pack_frame(RAW_MAX, RAW_MAX, RAW_MAX, RAW_MAX, RAW_MAX, RAW_MAX));
    send_frame(1'b0, pack_frame(RAW_W'($urandom), RAW_W'($urandom), RAW_W'($urandom),
                                RAW_W'($urandom), RAW_W'($urandom), RAW_W'($urandom)));
  endtask

  // Sticks on, just inside and just outside the deadband on both sides;
  // aux3 at the centre, one step above and at both ends.
  task automatic test_deadband_edges();
    send_frame(1'b1, pack_frame(1500, 1520, 1480, 0, 0, 1500));
    send_frame(1'b1, pack_frame(1521, 1479, 1500, 0, 0, 1501));
    send_frame(1'b1, pack_frame(1479, 1521, 1520, RAW_MAX, 0, 0));
    send_frame(1'b1, pack_frame(1480, 1500, 1521, 1234, 0, RAW_MAX));
  endtask

  task automatic test_arming_gestures();
    // Switch at centre keeps the state; throttle at the check level must not arm.
    send_frame(1'b1, pack_frame(1500, 1500, 1500, 0, 1500, 0));
    send_frame(1'b1, pack_frame(1500, 1500, 1500, 1100, RAW_MAX, 0));
    send_frame(1'b1, pack_frame(1500, 1500, 1500, 1099, RAW_MAX, 0));
    send_frame(1'b1, pack_frame(1500, 1500, 1500, 1099, RAW_MAX, 0));
    // Throttle either side of the PID release level while armed.
    send_frame(1'b1, pack_frame(2000, 1000, 1600, 1150, RAW_MAX, 0));
    send_frame(1'b1, pack_frame(2000, 1000, 1600, 1151, RAW_MAX, RAW_MAX));
    send_frame(1'b0, pack_frame(0, 0, 0, 0, 0, 0));
    send_frame(1'b1, pack_frame(1500, 1500, 1500, RAW_MAX, 1500, 0));
    send_frame(1'b1, pack_frame(RAW_MAX, 0, 0, 0, 0, 0));
    send_frame(1'b1, pack_frame(RAW_MAX, RAW_MAX, 0, 0, 0, 0));
    send_frame(1'b1, pack_frame(0, 0, RAW_MAX, 0, 0, 0));
  endtask

  task automatic test_register_extremes();
    program_regs(0, 0, 16'hFFFF, 0, DBL_MAX, 0);
    repeat (12) send_random_frame();
    program_regs(DBL_MAX, 1000, 16'hFFFF, DBL_MAX, 0, DBL_MAX);
    repeat (12) send_random_frame();
    program_regs(3000, 1000, 0, 2200, 3800, 2300);
    repeat (12) send_random_frame();
    // With no deadband only an exactly centred stick reads as a detent.
    program_regs(3000, 0, 16384, 2200, 3800, 2300);
    repeat (12) send_random_frame();
    program_regs(4001, 0, 1, 1000, 7000, 4000);
    repeat (12) send_random_frame();
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct  = 18;
          sink_idle_pct = 88;
        end
        1: begin
          src_idle_pct  = 88;
          sink_idle_pct = 18;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
      endcase
      for (int seg = 0; seg < 4; seg++) begin
        program_random_regs();
        repeat (SEGMENT_ITEMS) send_random_frame();
      end
    end
  endtask

  initial begin
    reset_model();
    src_idle_pct  = 18;
    sink_idle_pct = 88;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_extremes();
    test_deadband_edges();
    test_arming_gestures();
    test_register_extremes();
    test_random_traffic();
    wait_idle();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
